[rtl/esc_steer_mapper_with_brake_top_macros.svh]
// Assertion macros for the checker file of the ESC steering mapper.
`ifndef ESC_STEER_MAPPER_WITH_BRAKE_TOP_MACROS_SVH
`define ESC_STEER_MAPPER_WITH_BRAKE_TOP_MACROS_SVH

// Same-cycle implication, switched off while reset is high.
`define ESCSM_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, switched off while reset is high.
`define ESCSM_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication that is also checked across reset.
`define ESCSM_ASSERT_NEXT_ALWAYS(label, ante, cons, msg) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/escsm_pkg.sv]
// Package with the item types, register codes and constants of the ESC steering mapper.
`default_nettype none

package escsm_pkg;

   // Brake sequencer modes.
   localparam logic [1:0] MODE_DIRECT = 2'd0;
   localparam logic [1:0] MODE_BRAKE  = 2'd1;
   localparam logic [1:0] MODE_HOLD   = 2'd2;

   // Configuration register indexes.
   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 16;
   localparam logic [CSR_INDEX_W-1:0] CSR_FWD_THRESHOLD = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BRAKE_TRIGGER = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BRAKE_DUR     = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_HOLD_DUR      = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_STEER_DB      = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_ESC_DB        = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_BRAKE_PULSE   = 3'd6;

   // Register reset values.
   localparam logic signed [8:0] RST_FWD_THRESHOLD = 9'sd60;
   localparam logic signed [8:0] RST_BRAKE_TRIGGER = -9'sd20;
   localparam logic [15:0]       RST_BRAKE_DUR     = 16'd250;
   localparam logic [15:0]       RST_HOLD_DUR      = 16'd200;
   localparam logic [8:0]        RST_STEER_DB      = 9'd10;
   localparam logic [8:0]        RST_ESC_DB        = 9'd20;
   localparam logic [10:0]       RST_BRAKE_PULSE   = 11'd1000;

   // Pulse widths in microseconds.
   localparam logic [10:0] PULSE_MIN = 11'd1000;
   localparam logic [10:0] PULSE_MID = 11'd1500;
   localparam logic [10:0] PULSE_MAX = 11'd2000;

   // Input item.
   typedef struct packed {
      logic signed [8:0] throttle;
      logic [7:0]        steer;
      logic [31:0]       now_ms;
   } req_type;

   // Result item.
   typedef struct packed {
      logic [10:0] steer_pulse_us;
      logic [10:0] esc_pulse_us;
      logic [1:0]  brake_mode;
   } rsp_type;

   // Configuration seen by the datapath.
   typedef struct packed {
      logic signed [8:0] forward_active_threshold;
      logic signed [8:0] brake_trigger_level;
      logic [15:0]       brake_duration_ms;
      logic [15:0]       neutral_hold_ms;
      logic [8:0]        steer_deadband_us;
      logic [8:0]        esc_deadband_us;
      logic [10:0]       brake_esc_us;
   } cfg_type;

endpackage

`default_nettype wire

[rtl/escsm_csr.sv]
// Configuration register file of the ESC steering mapper.
`default_nettype none

module escsm_csr (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  csr_valid,
   input  wire logic [escsm_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [escsm_pkg::CSR_DATA_W-1:0]      csr_wdata,
   output escsm_pkg::cfg_type                         cfg
);

   escsm_pkg::cfg_type cfg_ff;
   escsm_pkg::cfg_type cfg_in;

   // Decode a write into the addressed field; unknown indexes are ignored.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            escsm_pkg::CSR_FWD_THRESHOLD: cfg_in.forward_active_threshold = csr_wdata[8:0];
            escsm_pkg::CSR_BRAKE_TRIGGER: cfg_in.brake_trigger_level      = csr_wdata[8:0];
            escsm_pkg::CSR_BRAKE_DUR:     cfg_in.brake_duration_ms        = csr_wdata[15:0];
            escsm_pkg::CSR_HOLD_DUR:      cfg_in.neutral_hold_ms          = csr_wdata[15:0];
            escsm_pkg::CSR_STEER_DB:      cfg_in.steer_deadband_us        = csr_wdata[8:0];
            escsm_pkg::CSR_ESC_DB:        cfg_in.esc_deadband_us          = csr_wdata[8:0];
            escsm_pkg::CSR_BRAKE_PULSE:   cfg_in.brake_esc_us             = csr_wdata[10:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   // Registers with their documented reset values.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.forward_active_threshold <= escsm_pkg::RST_FWD_THRESHOLD;
         cfg_ff.brake_trigger_level      <= escsm_pkg::RST_BRAKE_TRIGGER;
         cfg_ff.brake_duration_ms        <= escsm_pkg::RST_BRAKE_DUR;
         cfg_ff.neutral_hold_ms          <= escsm_pkg::RST_HOLD_DUR;
         cfg_ff.steer_deadband_us        <= escsm_pkg::RST_STEER_DB;
         cfg_ff.esc_deadband_us          <= escsm_pkg::RST_ESC_DB;
         cfg_ff.brake_esc_us             <= escsm_pkg::RST_BRAKE_PULSE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

[rtl/escsm_core.sv]
// Pulse mapping datapath and brake sequencer state of the ESC steering mapper.
`default_nettype none

module escsm_core (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                advance,
   input  wire escsm_pkg::req_type  item,
   input  wire escsm_pkg::cfg_type  cfg,
   output escsm_pkg::rsp_type       result
);

   // Reciprocals: x / 9 as (x * 116509) >> 20 for x below 2^14,
   // and x / 51 as (x * 41121) >> 21 for x below 2^15.
   localparam logic [16:0] RECIP_9  = 17'd116509;
   localparam logic [16:0] RECIP_51 = 17'd41121;

   logic [1:0]        mode_ff;
   logic [1:0]        mode_in;
   logic [31:0]       deadline_ff;
   logic [31:0]       deadline_in;
   logic signed [8:0] last_thr_ff;
   logic signed [8:0] last_thr_in;

   logic signed [8:0] thr;
   logic [13:0]       steer_x50;
   logic [30:0]       steer_prod;
   logic [10:0]       steer_q;
   logic [11:0]       steer_raw;
   logic [10:0]       steer_clamped;
   logic [10:0]       steer_us;
   logic [7:0]        thr_mag;
   logic [14:0]       thr_x100;
   logic [31:0]       thr_prod;
   logic [8:0]        thr_q;
   logic [10:0]       esc_mapped;
   logic [10:0]       esc_snapped;
   logic [10:0]       esc_us;
   logic              done;

   // True when a pulse lies within the deadband of the centre value.
   function automatic logic near_centre(input logic [10:0] v, input logic [8:0] db);
      logic [10:0] gap;
      gap = (v >= escsm_pkg::PULSE_MID) ? (v - escsm_pkg::PULSE_MID)
                                        : (escsm_pkg::PULSE_MID - v);
      return gap <= {2'b00, db};
   endfunction

   assign thr = item.throttle;

   // Steering: steer * 1000 / 180 + 1000, clamped at the top, then snapped.
   always_comb begin
      steer_x50     = 14'(item.steer) * 14'd50;
      steer_prod    = 31'(steer_x50) * 31'(RECIP_9);
      steer_q       = steer_prod[30:20];
      steer_raw     = 12'(steer_q) + 12'(escsm_pkg::PULSE_MIN);
      steer_clamped = (steer_raw > 12'(escsm_pkg::PULSE_MAX)) ? escsm_pkg::PULSE_MAX
                                                              : steer_raw[10:0];
      steer_us      = near_centre(steer_clamped, cfg.steer_deadband_us) ? escsm_pkg::PULSE_MID
                                                                        : steer_clamped;
   end

   // Throttle: each half maps onto 500 us; the most negative code counts as -255.
   always_comb begin
      if (!thr[8]) begin
         thr_mag = thr[7:0];
      end else if (thr[7:0] == 8'd0) begin
         thr_mag = 8'd0;
      end else begin
         thr_mag = thr[7:0] - 8'd1;
      end
      thr_x100    = 15'(thr_mag) * 15'd100;
      thr_prod    = 32'(thr_x100) * 32'(RECIP_51);
      thr_q       = thr_prod[29:21];
      esc_mapped  = (thr[8] ? escsm_pkg::PULSE_MIN : escsm_pkg::PULSE_MID) + 11'(thr_q);
      esc_snapped = near_centre(esc_mapped, cfg.esc_deadband_us) ? escsm_pkg::PULSE_MID
                                                                 : esc_mapped;
   end

   // Brake sequencer: running phases first, then direct mode with brake detection.
   always_comb begin
      mode_in     = mode_ff;
      deadline_in = deadline_ff;
      last_thr_in = last_thr_ff;
      esc_us      = escsm_pkg::PULSE_MID;
      done        = 1'b0;
      if (mode_ff != escsm_pkg::MODE_DIRECT) begin
         if (item.now_ms < deadline_ff) begin
            esc_us = (mode_ff == escsm_pkg::MODE_BRAKE) ? cfg.brake_esc_us
                                                        : escsm_pkg::PULSE_MID;
            done   = 1'b1;
         end else if (mode_ff == escsm_pkg::MODE_BRAKE) begin
            mode_in     = escsm_pkg::MODE_HOLD;
            deadline_in = item.now_ms + 32'(cfg.neutral_hold_ms);
            done        = 1'b1;
         end else begin
            mode_in = escsm_pkg::MODE_DIRECT;
         end
      end
      if (!done) begin
         if (last_thr_ff > cfg.forward_active_threshold && thr < cfg.brake_trigger_level) begin
            mode_in     = escsm_pkg::MODE_BRAKE;
            deadline_in = item.now_ms + 32'(cfg.brake_duration_ms);
            esc_us      = cfg.brake_esc_us;
         end else begin
            esc_us = esc_snapped;
         end
         last_thr_in = thr;
      end
   end

   // Sequencer state moves on only when the item passes to the result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= escsm_pkg::MODE_DIRECT;
         deadline_ff <= 32'd0;
         last_thr_ff <= 9'sd0;
      end else if (advance) begin
         mode_ff     <= mode_in;
         deadline_ff <= deadline_in;
         last_thr_ff <= last_thr_in;
      end
   end

   assign result.steer_pulse_us = steer_us;
   assign result.esc_pulse_us   = esc_us;
   assign result.brake_mode     = mode_in;

endmodule

`default_nettype wire

[rtl/esc_steer_mapper_with_brake_top.sv]
// Top level of the RC steering and ESC pulse mapper with brake sequencer.
//
// Usage:
//   Input items (throttle, steer, now_ms) arrive on req_valid / req_data and are
//   taken at a clock edge where req_valid is high and req_stall is low. Each item
//   gives exactly one result item (steer_pulse_us, esc_pulse_us, brake_mode) on
//   rsp_valid / rsp_data, taken where rsp_valid is high and rsp_stall is low.
//   An item taken at one edge sits in the input register, passes through the
//   mapping and sequencer logic into the result register at the first edge where
//   that register is empty or being read out, and is shown on rsp_valid from then
//   on. Throughput is one item per cycle while the receiver keeps rsp_stall low.
//   When rsp_stall is high the result register holds its item; one further item
//   waits in the input register, and req_stall rises only once both are full.
//   Registers are written over csr_valid / csr_index / csr_wdata; csr_ready is
//   always high and a write takes effect on the following cycle. The user must
//   make writes only while no item is in flight; the block does not enforce this.
//   Synchronous reset empties both registers, returns the sequencer to direct
//   mode with a zero deadline and zero last throttle, and restores the
//   register defaults.
`default_nettype none

module esc_steer_mapper_with_brake_top (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire escsm_pkg::req_type                req_data,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output escsm_pkg::rsp_type                     rsp_data,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [escsm_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [escsm_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   logic               in_valid_ff;
   logic               in_valid_in;
   escsm_pkg::req_type in_item_ff;
   logic               out_valid_ff;
   logic               out_valid_in;
   escsm_pkg::rsp_type out_item_ff;
   escsm_pkg::rsp_type core_result;
   escsm_pkg::cfg_type cfg;
   logic               out_free;
   logic               advance;
   logic               accept;

   // Pipeline flow control.
   assign out_free     = !out_valid_ff || !rsp_stall;
   assign advance      = in_valid_ff && out_free;
   assign req_stall    = in_valid_ff && !out_free;
   assign accept       = req_valid && !req_stall;
   assign in_valid_in  = (in_valid_ff && !advance) || accept;
   assign out_valid_in = advance || (out_valid_ff && rsp_stall);

   // Valid flags.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         in_item_ff <= req_data;
      end
      if (advance) begin
         out_item_ff <= core_result;
      end
   end

   // Configuration registers.
   escsm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // Mapping datapath and sequencer.
   escsm_core u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (in_item_ff),
      .cfg     (cfg),
      .result  (core_result)
   );

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_item_ff;
   assign csr_ready = 1'b1;

endmodule

`default_nettype wire

[rtl/escsm_checker.sv]
// Port-level checker of the ESC steering mapper, bound to the top level.
`default_nettype none

`include "esc_steer_mapper_with_brake_top_macros.svh"

module escsm_checker (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               rsp_valid,
   input wire logic               rsp_stall,
   input wire escsm_pkg::rsp_type rsp_data
);

   logic rsp_held;
   logic mode_known;
   logic steer_in_range;

   // Terms used by the properties below.
   assign rsp_held       = rsp_valid && rsp_stall;
   assign mode_known     = (rsp_data.brake_mode == escsm_pkg::MODE_DIRECT) ||
                           (rsp_data.brake_mode == escsm_pkg::MODE_BRAKE) ||
                           (rsp_data.brake_mode == escsm_pkg::MODE_HOLD);
   assign steer_in_range = (rsp_data.steer_pulse_us >= escsm_pkg::PULSE_MIN) &&
                           (rsp_data.steer_pulse_us <= escsm_pkg::PULSE_MAX);

   // A stalled result item stays offered unchanged.
   `ESCSM_ASSERT_NEXT(a_rsp_hold, rsp_held, rsp_valid && $stable(rsp_data), "stalled item changed")

   // Reset empties the result register.
   `ESCSM_ASSERT_NEXT_ALWAYS(a_rsp_reset, reset, !rsp_valid, "result valid after reset")

   // The sequencer never reports an undefined mode.
   `ESCSM_ASSERT_NOW(a_mode_code, rsp_valid, mode_known, "undefined brake mode")

   // Steering pulses always lie in the servo range.
   `ESCSM_ASSERT_NOW(a_steer_range, rsp_valid, steer_in_range, "steering pulse out of range")

endmodule

bind esc_steer_mapper_with_brake_top escsm_checker u_escsm_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

`default_nettype wire
